// File: rtl/bilinear_grid_sampler_defines.svh
// Assertion macros for the grid sampler. Synthesis builds define SYNTH and get
// empty bodies.
`ifndef BILINEAR_GRID_SAMPLER_DEFINES_SVH
`define BILINEAR_GRID_SAMPLER_DEFINES_SVH

`ifndef SYNTH
// Property checked at every rising edge outside of reset.
`define BGS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked at every rising edge, reset included.
`define BGS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BGS_ASSERT(label, clk, rst, prop, msg)
`define BGS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: rtl/bgs_pkg.sv
package bgs_pkg;

   // Field widths of the request and response channels.
   localparam int DATA_W            = 16;
   localparam int ADDR_W            = 16;
   localparam int POS_W             = 16;
   localparam int MAX_FRACTION_BITS = 16;

   // A weight is a product of two distances of up to 2^FRACTION_BITS each.
   localparam int WEIGHT_W = 2 * MAX_FRACTION_BITS + 1;
   localparam int PROD_W   = WEIGHT_W + 1 + DATA_W;
   localparam int SUM_W    = PROD_W + 2;

   // Four neighbours per query.
   localparam int TAPS  = 4;
   localparam int TAP_W = 2;

   localparam int QUEUE_DEPTH = 2;

   // Sample code that marks a missing elevation.
   localparam logic [DATA_W-1:0] NO_DATA = 16'h8000;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_DATA = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   // What the back end has to do with one queued request.
   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_RANGE = 2'd2
   } cmd_type;

   typedef struct packed {
      cmd_type                          cmd;
      logic [DATA_W-1:0]                value;
      logic [TAPS-1:0][ADDR_W-1:0]      addr;
      logic [TAPS-1:0][WEIGHT_W-1:0]    weight;
   } work_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] wdata;
   } ram_cmd_type;

endpackage

// File: rtl/bilinear_grid_sampler.sv
// Bilinear grid sampler.
// Request channel (req_valid/req_stall): req_type 0 writes req_sample_value to
// grid entry req_sample_index; req_type 1 asks for the elevation at
// (req_column_pos, req_row_pos), unsigned with FRACTION_BITS fractional bits.
// Response channel (rsp_valid/rsp_stall): exactly one response per request, in
// request order: rsp_elevation in decimetres and rsp_status (0 ok or load done,
// 1 no data, 2 out of range).
// A query reads the single-port grid memory once per neighbour, four reads
// in all, and the sequencer starts the next entry once the last read issues;
// a load takes one memory write and an out-of-range query no memory access.
// Each result passes the tap, product, total and response registers in turn.
// A two-entry queue separates request classification from the memory sequencer,
// so requests keep being accepted while a response waits.
// While a response waits with rsp_stall high the sequencer and its pipeline
// hold; req_stall rises once the queue is full.
// Reset clears the control state; grid contents are undefined until loaded.
`include "bilinear_grid_sampler_defines.svh"

module bilinear_grid_sampler #(
   parameter int CELLS         = 255,
   parameter int FRACTION_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic [bgs_pkg::ADDR_W-1:0]        req_sample_index,
   input  logic signed [bgs_pkg::DATA_W-1:0] req_sample_value,
   input  logic [bgs_pkg::POS_W-1:0]         req_column_pos,
   input  logic [bgs_pkg::POS_W-1:0]         req_row_pos,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [bgs_pkg::DATA_W-1:0] rsp_elevation,
   output logic [1:0]                        rsp_status
);

   localparam int GRID_DEPTH = 1 << bgs_pkg::ADDR_W;

   bgs_pkg::work_type          work;
   bgs_pkg::work_type          head;
   bgs_pkg::queue_status_type  q_status;
   bgs_pkg::ram_cmd_type       ram_cmd;
   logic [bgs_pkg::DATA_W-1:0] ram_rdata;
   logic                       q_push;
   logic                       q_pop;

   // Requests are taken whenever the queue has room.
   assign req_stall = q_status.full;
   assign q_push    = req_valid && !req_stall;

   bgs_front #(
      .CELLS         (CELLS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .req_type     (req_type),
      .sample_index (req_sample_index),
      .sample_value (req_sample_value),
      .column_pos   (req_column_pos),
      .row_pos      (req_row_pos),
      .work         (work)
   );

   bgs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (work),
      .pop       (q_pop),
      .head      (head),
      .status    (q_status)
   );

   bgs_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_status      (q_status),
      .pop           (q_pop),
      .ram_cmd       (ram_cmd),
      .ram_rdata     (ram_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_elevation (rsp_elevation),
      .rsp_status    (rsp_status)
   );

   bgs_ram #(
      .WIDTH (bgs_pkg::DATA_W),
      .DEPTH (GRID_DEPTH)
   ) u_grid (
      .clock (clock),
      .en    (ram_cmd.en),
      .we    (ram_cmd.we),
      .addr  (ram_cmd.addr),
      .wdata (ram_cmd.wdata),
      .rdata (ram_rdata)
   );

   // The request side stalls only when the queue actually holds entries.
   `BGS_ASSERT(a_stall_not_empty, clock, reset, req_stall |-> !q_status.empty, "stall with empty queue")
   // The sequencer never takes an entry from an empty queue.
   `BGS_ASSERT(a_pop_not_empty, clock, reset, q_pop |-> !q_status.empty, "pop from empty queue")
   // A stalled response freezes the sequencer.
   `BGS_ASSERT(a_hold_on_stall, clock, reset, (rsp_valid && rsp_stall) |-> !q_pop, "pop while stalled")
   // No response is offered right after reset.
   `BGS_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "response after reset")

endmodule

// File: rtl/bgs_ram.sv
module bgs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/bgs_front.sv
module bgs_front #(
   parameter int CELLS         = 255,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                 req_type,
   input  logic [bgs_pkg::ADDR_W-1:0]           sample_index,
   input  logic signed [bgs_pkg::DATA_W-1:0]    sample_value,
   input  logic [bgs_pkg::POS_W-1:0]            column_pos,
   input  logic [bgs_pkg::POS_W-1:0]            row_pos,
   output bgs_pkg::work_type                    work
);

   localparam int LIMIT_W = bgs_pkg::POS_W + 8;
   localparam logic [LIMIT_W-1:0] LIMIT = LIMIT_W'(CELLS) << FRACTION_BITS;
   localparam int FRAC_W = bgs_pkg::MAX_FRACTION_BITS + 1;
   localparam logic [FRAC_W-1:0] ONE  = FRAC_W'(1) << FRACTION_BITS;
   localparam logic [FRAC_W-1:0] MASK = ONE - FRAC_W'(1);
   localparam logic [8:0] LAST = 9'(CELLS);
   localparam logic [8:0] SIDE = 9'(CELLS + 1);

   logic [bgs_pkg::POS_W-1:0] col_int;
   logic [bgs_pkg::POS_W-1:0] row_int;
   logic [8:0]                c0;
   logic [8:0]                c1;
   logic [8:0]                r0;
   logic [8:0]                r1;
   logic [FRAC_W-1:0]         fc;
   logic [FRAC_W-1:0]         fr;
   logic [FRAC_W-1:0]         gc;
   logic [FRAC_W-1:0]         gr;
   logic [17:0]               base0;
   logic [17:0]               base1;
   logic [2*FRAC_W-1:0]       wt [bgs_pkg::TAPS];
   logic                      out_of_range;

   // Split the positions into cell index and fraction; clamp the upper neighbour.
   always_comb begin
      col_int = column_pos >> FRACTION_BITS;
      row_int = row_pos >> FRACTION_BITS;
      c0 = col_int[8:0];
      r0 = row_int[8:0];
      c1 = (c0 >= LAST) ? LAST : c0 + 9'd1;
      r1 = (r0 >= LAST) ? LAST : r0 + 9'd1;
      fc = FRAC_W'(column_pos) & MASK;
      fr = FRAC_W'(row_pos) & MASK;
      gc = ONE - fc;
      gr = ONE - fr;
      out_of_range = ({8'd0, column_pos} > LIMIT) || ({8'd0, row_pos} > LIMIT);
   end

   // Row bases and the four bilinear weights, computed side by side.
   always_comb begin
      base0 = r0 * SIDE;
      base1 = r1 * SIDE;
      wt[0] = gc * gr;
      wt[1] = fc * gr;
      wt[2] = gc * fr;
      wt[3] = fc * fr;
   end

   // Classify the request and build the queue entry.
   always_comb begin
      work.value = sample_value;
      work.addr[0] = bgs_pkg::ADDR_W'(base0 + 18'(c0));
      work.addr[1] = bgs_pkg::ADDR_W'(base0 + 18'(c1));
      work.addr[2] = bgs_pkg::ADDR_W'(base1 + 18'(c0));
      work.addr[3] = bgs_pkg::ADDR_W'(base1 + 18'(c1));
      for (int i = 0; i < bgs_pkg::TAPS; i++) begin
         work.weight[i] = wt[i][bgs_pkg::WEIGHT_W-1:0];
      end
      if (bgs_pkg::req_kind_type'(req_type) == bgs_pkg::REQ_LOAD) begin
         work.cmd     = bgs_pkg::CMD_LOAD;
         work.addr[0] = sample_index;
      end else if (out_of_range) begin
         work.cmd = bgs_pkg::CMD_RANGE;
      end else begin
         work.cmd = bgs_pkg::CMD_QUERY;
      end
   end

endmodule

// File: rtl/bgs_queue.sv
module bgs_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bgs_pkg::work_type          push_data,
   input  logic                       pop,
   output bgs_pkg::work_type          head,
   output bgs_pkg::queue_status_type  status
);

   localparam int CNT_W = $clog2(bgs_pkg::QUEUE_DEPTH + 1);
   localparam int PTR_W = $clog2(bgs_pkg::QUEUE_DEPTH);

   bgs_pkg::work_type slot_ff [bgs_pkg::QUEUE_DEPTH];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;

   // Occupancy and pointer updates.
   always_comb begin
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(bgs_pkg::QUEUE_DEPTH));

endmodule

// File: rtl/bgs_back.sv
module bgs_back #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bgs_pkg::work_type                 head,
   input  bgs_pkg::queue_status_type         q_status,
   output logic                              pop,
   output bgs_pkg::ram_cmd_type              ram_cmd,
   input  logic [bgs_pkg::DATA_W-1:0]        ram_rdata,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [bgs_pkg::DATA_W-1:0] rsp_elevation,
   output logic [1:0]                        rsp_status
);

   localparam int SHIFT = 2 * FRACTION_BITS;
   localparam logic [bgs_pkg::SUM_W-1:0] HALF = bgs_pkg::SUM_W'(1) << (SHIFT - 1);

   typedef struct packed {
      logic                             valid;
      logic                             first;
      logic                             last;
      bgs_pkg::cmd_type                 cmd;
      logic [bgs_pkg::WEIGHT_W-1:0]     weight;
   } tap_type;

   typedef struct packed {
      logic                             valid;
      logic                             first;
      logic                             last;
      bgs_pkg::cmd_type                 cmd;
      logic                             no_data;
      logic [bgs_pkg::PROD_W-1:0]       prod;
   } prod_type;

   typedef struct packed {
      logic                             valid;
      bgs_pkg::cmd_type                 cmd;
      logic                             no_data;
      logic [bgs_pkg::SUM_W-1:0]        sum;
   } total_type;

   logic                              adv;
   logic                              issue;
   logic                              last_tap;
   logic [bgs_pkg::TAP_W-1:0]         idx_ff;
   logic [bgs_pkg::TAP_W-1:0]         idx_in;
   tap_type                           tap_ff;
   tap_type                           tap_in;
   prod_type                          prod_ff;
   prod_type                          prod_in;
   total_type                         total_ff;
   total_type                         total_in;
   logic [bgs_pkg::SUM_W-1:0]         acc_ff;
   logic [bgs_pkg::SUM_W-1:0]         acc_in;
   logic                              nd_ff;
   logic                              nd_in;
   logic signed [bgs_pkg::DATA_W-1:0] sample;
   logic signed [bgs_pkg::PROD_W-1:0] product;
   logic [bgs_pkg::SUM_W-1:0]         rounded;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [bgs_pkg::DATA_W-1:0]        elevation_ff;
   logic [bgs_pkg::DATA_W-1:0]        elevation_in;
   bgs_pkg::status_type               status_ff;
   bgs_pkg::status_type               status_in;

   // The whole back pipeline moves only when the output slot can take a result.
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign issue = adv && !q_status.empty;

   // Sequencer: one memory access per cycle while the pipeline advances and the queue holds entries, four for a query.
   always_comb begin
      last_tap = (head.cmd != bgs_pkg::CMD_QUERY) ||
                 (idx_ff == bgs_pkg::TAP_W'(bgs_pkg::TAPS - 1));
      pop = issue && last_tap;
      idx_in = idx_ff;
      if (issue && head.cmd == bgs_pkg::CMD_QUERY) begin
         idx_in = last_tap ? '0 : idx_ff + bgs_pkg::TAP_W'(1);
      end
      ram_cmd.en    = issue && (head.cmd != bgs_pkg::CMD_RANGE);
      ram_cmd.we    = (head.cmd == bgs_pkg::CMD_LOAD);
      ram_cmd.addr  = head.addr[idx_ff];
      ram_cmd.wdata = head.value;
      tap_in.valid  = !q_status.empty;
      tap_in.first  = (idx_ff == '0);
      tap_in.last   = last_tap;
      tap_in.cmd    = head.cmd;
      tap_in.weight = head.weight[idx_ff];
   end

   // Weight times sample, aligned with the registered memory read. A neighbour
   // without weight adds nothing, whatever its sample holds.
   always_comb begin
      sample = $signed(ram_rdata);
      if (tap_ff.weight == '0) begin
         product = '0;
      end else begin
         product = $signed({1'b0, tap_ff.weight}) * sample;
      end
      prod_in.valid   = tap_ff.valid;
      prod_in.first   = tap_ff.first;
      prod_in.last    = tap_ff.last;
      prod_in.cmd     = tap_ff.cmd;
      prod_in.no_data = (tap_ff.cmd == bgs_pkg::CMD_QUERY) && (tap_ff.weight != '0) &&
                        (ram_rdata == bgs_pkg::NO_DATA);
      prod_in.prod    = product;
   end

   // Accumulate the weighted samples of one query.
   always_comb begin
      acc_in = (prod_ff.first ? '0 : acc_ff) +
               {{(bgs_pkg::SUM_W - bgs_pkg::PROD_W){prod_ff.prod[bgs_pkg::PROD_W-1]}},
                prod_ff.prod};
      nd_in  = (prod_ff.first ? 1'b0 : nd_ff) | prod_ff.no_data;
      total_in.valid   = prod_ff.valid && prod_ff.last;
      total_in.cmd     = prod_ff.cmd;
      total_in.no_data = nd_in;
      total_in.sum     = acc_in;
   end

   // Round to nearest with ties away from zero, then pick the status.
   always_comb begin
      rounded = total_ff.sum + HALF - bgs_pkg::SUM_W'(total_ff.sum[bgs_pkg::SUM_W-1]);
      rsp_valid_in = total_ff.valid;
      elevation_in = '0;
      status_in    = bgs_pkg::STATUS_OK;
      case (total_ff.cmd)
         bgs_pkg::CMD_LOAD: begin
            status_in = bgs_pkg::STATUS_OK;
         end
         bgs_pkg::CMD_RANGE: begin
            status_in = bgs_pkg::STATUS_RANGE;
         end
         bgs_pkg::CMD_QUERY: begin
            if (total_ff.no_data) begin
               status_in = bgs_pkg::STATUS_NO_DATA;
            end else begin
               elevation_in = rounded[SHIFT +: bgs_pkg::DATA_W];
            end
         end
         default: begin
            status_in = bgs_pkg::STATUS_OK;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff         <= '0;
         tap_ff.valid   <= 1'b0;
         prod_ff.valid  <= 1'b0;
         total_ff.valid <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else if (adv) begin
         idx_ff         <= idx_in;
         tap_ff.valid   <= tap_in.valid;
         prod_ff.valid  <= prod_in.valid;
         total_ff.valid <= total_in.valid;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         tap_ff.first    <= tap_in.first;
         tap_ff.last     <= tap_in.last;
         tap_ff.cmd      <= tap_in.cmd;
         tap_ff.weight   <= tap_in.weight;
         prod_ff.first   <= prod_in.first;
         prod_ff.last    <= prod_in.last;
         prod_ff.cmd     <= prod_in.cmd;
         prod_ff.no_data <= prod_in.no_data;
         prod_ff.prod    <= prod_in.prod;
         if (prod_ff.valid) begin
            acc_ff <= acc_in;
            nd_ff  <= nd_in;
         end
         total_ff.cmd     <= total_in.cmd;
         total_ff.no_data <= total_in.no_data;
         total_ff.sum     <= total_in.sum;
         elevation_ff     <= elevation_in;
         status_ff        <= status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_elevation = $signed(elevation_ff);
   assign rsp_status    = status_ff;

endmodule
